// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define KLCD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define KLCD_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/klcd_pkg.sv =====
// Shared types, constants and saturation helpers of the KL coordinate descent solver.
// No dependencies.
package klcd_pkg;

  localparam int ROWS    = 256;
  localparam int FACTORS = 16;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int FAC_W   = $clog2(FACTORS);
  localparam int WADDR_W = ROW_W + FAC_W;

  localparam logic signed [39:0] ONE_Q16 = 40'sd65536;

  // divider: 40 bit magnitude shifted by 16
  localparam int DIV_STEPS = 56;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_LOAD_W  = 2'd0,
    OP_LOAD_D  = 2'd1,
    OP_LOAD_H  = 2'd2,
    OP_START   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_L1     = 2'd0,
    REG_L2     = 2'd1,
    REG_TOL    = 2'd2,
    REG_MAXSW  = 2'd3
  } reg_idx_t;

  localparam logic [23:0] L1_RST    = 24'd655;
  localparam logic [23:0] L2_RST    = 24'd0;
  localparam logic [15:0] TOL_RST   = 16'd7;
  localparam logic [7:0]  MAXSW_RST = 8'd100;

  typedef struct packed {
    logic [23:0] l1;
    logic [23:0] l2;
    logic [15:0] tol;
    logic [7:0]  max_sw;
  } cfg_t;

  typedef struct packed {
    logic [FAC_W-1:0]   out_index;
    logic signed [31:0] factor_value;
    logic [7:0]         sweeps_used;
    logic               last;
  } res_t;

  function automatic logic signed [39:0] sat40(input logic signed [51:0] x);
    logic signed [39:0] y;
    if (x[51:39] == {13{x[39]}}) y = x[39:0];
    else if (x[51]) y = {1'b1, 39'd0};
    else y = {1'b0, {39{1'b1}}};
    return y;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    logic signed [31:0] y;
    if (x[51:31] == {21{x[31]}}) y = x[31:0];
    else if (x[51]) y = {1'b1, 31'd0};
    else y = {1'b0, {31{1'b1}}};
    return y;
  endfunction

endpackage

// ===== hw/rtl/kl_coordinate_descent_nmf.sv =====
// Channel   Dir  Fields
// s_*       in   tuser: op; tdata: row_index, factor_index, value
// m_*       out  tdata: out_index, factor_value, sweeps_used; tlast: last
// APB       cfg  l1_penalty @0, l2_penalty @4, rel_tolerance @8, max_sweeps @12
//
// Loads are accepted one per cycle, back to back, while idle. A start first
// builds column sums and the model column, then per sweep and factor runs
// one 56-step divide per row and one for the new factor, plus a change
// divide and a model update over all rows when the factor changes (only the
// update when it clamps to zero), then emits 16 results. The serial divider
// sets the pace. Reset is synchronous; memories need no clearing. Results
// wait in an output register while m_tready is low.
module kl_coordinate_descent_nmf (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // row_index[7:0], factor_index[11:8], value[43:12], zero
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_index[3:0], factor_value[35:4], sweeps_used[43:36], zero
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import klcd_pkg::*;

  cfg_t     cfg;
  reg_idx_t ridx;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  res_t     out_q;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.l1     <= L1_RST;
      cfg.l2     <= L2_RST;
      cfg.tol    <= TOL_RST;
      cfg.max_sw <= MAXSW_RST;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_L1:    cfg.l1     <= pwdata[23:0];
        REG_L2:    cfg.l2     <= pwdata[23:0];
        REG_TOL:   cfg.tol    <= pwdata[15:0];
        REG_MAXSW: cfg.max_sw <= pwdata[7:0];
        default:   cfg.l1     <= cfg.l1;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_L1:    prdata = {8'd0, cfg.l1};
      REG_L2:    prdata = {8'd0, cfg.l2};
      REG_TOL:   prdata = {16'd0, cfg.tol};
      REG_MAXSW: prdata = {24'd0, cfg.max_sw};
      default:   prdata = '0;
    endcase
  end

  klcd_core u_core (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_op(op_t'(s_tuser)), .in_row(s_tdata[7:0]), .in_fac(s_tdata[11:8]),
    .in_value(s_tdata[43:12]),
    .cfg(cfg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_tdata = {4'd0, out_q.sweeps_used, out_q.factor_value, out_q.out_index};
  assign m_tlast = out_q.last;

endmodule

// ===== hw/rtl/klcd_ram.sv =====
// Generic single-port synchronous RAM, registered read data.
// No dependencies.
module klcd_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/klcd_div.sv =====
// Radix-2 restoring divider for Q16.16 quotients, saturated to 32 bits.
// Depends on klcd_pkg.
module klcd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [39:0] num,
  input  logic signed [39:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import klcd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [39:0]          rem;
  logic [55:0]          dq;
  logic [39:0]          dmag;
  logic                 neg;
  logic                 nzero;
  logic                 nneg;
  logic                 dzero;
  logic [39:0]          nmag;
  logic [40:0]          rem_sh;
  logic [41:0]          sub;
  logic                 ge;

  assign nmag   = num[39] ? 40'(-num) : num;
  assign rem_sh = {rem, dq[55]};
  assign sub    = {1'b0, rem_sh} - {2'b00, dmag};
  assign ge     = !sub[41];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        dq    <= {nmag, 16'd0};
        dmag  <= den[39] ? 40'(-den) : den;
        neg   <= num[39] ^ den[39];
        nneg  <= num[39];
        nzero <= (num == '0);
        dzero <= (den == '0);
      end else if (busy) begin
        rem <= ge ? sub[39:0] : rem_sh[39:0];
        dq  <= {dq[54:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dzero) begin
      if (nzero) quo = '0;
      else if (nneg) quo = {1'b1, 31'd0};
      else quo = {1'b0, {31{1'b1}}};
    end else if (neg) begin
      if (dq > 56'h80000000) quo = {1'b1, 31'd0};
      else quo = 32'(-dq);
    end else begin
      if (dq > 56'h7FFFFFFF) quo = {1'b0, {31{1'b1}}};
      else quo = dq[31:0];
    end
  end

endmodule

// ===== hw/rtl/klcd_core.sv =====
// Solver sequencer: memories, shared multiplier and divider, sweep control.
// Depends on klcd_pkg, klcd_ram, klcd_div.
module klcd_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  klcd_pkg::op_t             in_op,
  input  logic [klcd_pkg::ROW_W-1:0] in_row,
  input  logic [klcd_pkg::FAC_W-1:0] in_fac,
  input  logic signed [31:0]        in_value,
  input  klcd_pkg::cfg_t            cfg,
  output logic                      res_valid,
  input  logic                      res_ready,
  output klcd_pkg::res_t            res
);
  import klcd_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_I_RD   = 25'h0000002,
    S_I_MUL  = 25'h0000004,
    S_I_ACC  = 25'h0000008,
    S_CHK    = 25'h0000010,
    S_R_RD   = 25'h0000020,
    S_R_DIV  = 25'h0000040,
    S_R_WAIT = 25'h0000080,
    S_R_M1   = 25'h0000100,
    S_R_M2   = 25'h0000200,
    S_R_M3   = 25'h0000400,
    S_R_M4   = 25'h0000800,
    S_F_A    = 25'h0001000,
    S_F_M    = 25'h0002000,
    S_F_N    = 25'h0004000,
    S_F_DIV  = 25'h0008000,
    S_F_WAIT = 25'h0010000,
    S_F_DEC  = 25'h0020000,
    S_C_WAIT = 25'h0040000,
    S_U_RD   = 25'h0080000,
    S_U_M1   = 25'h0100000,
    S_U_M2   = 25'h0200000,
    S_U_M3   = 25'h0400000,
    S_F_END  = 25'h0800000,
    S_EMIT   = 25'h1000000
  } state_t;

  state_t st;

  logic [ROW_W-1:0]   r;
  logic [FAC_W-1:0]   k;
  logic               r_last;
  logic               k_last;
  logic signed [31:0] fac [FACTORS];
  logic signed [39:0] colsum [FACTORS];
  logic signed [39:0] msum;
  logic signed [39:0] g;
  logic signed [39:0] c;
  logic signed [31:0] a;
  logic signed [39:0] num;
  logic signed [31:0] q;
  logic signed [31:0] qn;
  logic signed [31:0] mu;
  logic signed [31:0] mu2;
  logic signed [47:0] t;
  logic signed [63:0] prod;
  logic [7:0]         sweep_count;
  logic signed [39:0] change_sum;

  logic signed [31:0] h;
  logic signed [47:0] fl;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               accept;

  // memories
  logic               w_we, w_re;
  logic [WADDR_W-1:0] w_addr;
  logic [31:0]        w_rdata;
  logic signed [31:0] w_s;
  logic               d_we, d_re;
  logic [ROW_W-1:0]   d_addr;
  logic [31:0]        d_rdata;
  logic signed [31:0] d_s;
  logic               m_we, m_re;
  logic [39:0]        m_wdata;
  logic [39:0]        m_rdata;
  logic signed [39:0] m_s;

  // divider
  logic               div_start;
  logic signed [39:0] div_num;
  logic signed [39:0] div_den;
  logic               div_done;
  logic signed [31:0] div_quo;

  logic signed [39:0] msum_next;
  logic signed [39:0] n1;
  logic signed [32:0] diff;
  logic [32:0]        adiff;
  logic               run_more;

  assign h      = fac[k];
  assign fl     = prod[63:16];
  assign w_s    = w_rdata;
  assign d_s    = d_rdata;
  assign m_s    = m_rdata;
  assign r_last = (r == ROW_W'(ROWS - 1));
  assign k_last = (k == FAC_W'(FACTORS - 1));
  assign in_ready = (st == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign diff  = 33'(q) - 33'(h);
  assign adiff = diff[32] ? 33'(-diff) : diff;

  assign msum_next = sat40(((k == '0) ? 52'sd0 : 52'(msum)) + 52'(fl));
  assign n1        = sat40(52'(g) + 52'(fl));
  assign run_more  = (sweep_count < cfg.max_sw) && !change_sum[39] &&
                     (change_sum[39:4] > {20'd0, cfg.tol});

  klcd_ram #(.DEPTH(ROWS * FACTORS), .WIDTH(32)) u_wram (
    .clk(clk), .we(w_we), .re(w_re), .addr(w_addr), .wdata(in_value), .rdata(w_rdata)
  );
  klcd_ram #(.DEPTH(ROWS), .WIDTH(32)) u_dram (
    .clk(clk), .we(d_we), .re(d_re), .addr(d_addr), .wdata(in_value), .rdata(d_rdata)
  );
  klcd_ram #(.DEPTH(ROWS), .WIDTH(40)) u_mram (
    .clk(clk), .we(m_we), .re(m_re), .addr(r), .wdata(m_wdata), .rdata(m_rdata)
  );

  klcd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    w_we    = accept && (in_op == OP_LOAD_W);
    d_we    = accept && (in_op == OP_LOAD_D);
    w_re    = (st == S_I_RD) || (st == S_R_RD) || (st == S_U_RD);
    d_re    = (st == S_R_RD);
    m_re    = (st == S_R_RD) || (st == S_U_RD);
    w_addr  = (st == S_IDLE) ? {in_row, in_fac} : {r, k};
    d_addr  = (st == S_IDLE) ? in_row : r;
    m_we    = 1'b0;
    m_wdata = msum_next;
    if (st == S_I_ACC && k_last) m_we = 1'b1;
    if (st == S_U_M3) begin
      m_we    = 1'b1;
      m_wdata = sat40(52'(m_s) + 52'(t) - 52'(fl));
    end
  end

  // one multiplier shared by all the multiply steps
  always_comb begin
    mul_a = w_s;
    mul_b = h;
    case (st)
      S_R_M1:  begin mul_a = mu;  mul_b = mu;  end
      S_R_M2:  begin mul_a = d_s; mul_b = mu;  end
      S_R_M3:  begin mul_a = d_s; mul_b = mu2; end
      S_F_M:   begin mul_a = a;   mul_b = h;   end
      S_U_M1:  begin mul_a = w_s; mul_b = qn;  end
      default: begin mul_a = w_s; mul_b = h;   end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = 40'(w_s);
    div_den   = m_s;
    case (st)
      S_R_DIV: div_start = 1'b1;
      S_F_DIV: begin
        div_start = 1'b1;
        div_num   = num;
        div_den   = 40'(a);
      end
      S_F_DEC: begin
        div_start = !q[31] && (q != h);
        div_num   = $signed({7'd0, adiff});
        div_den   = 40'(h);
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      r           <= '0;
      k           <= '0;
      sweep_count <= '0;
      change_sum  <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (accept && in_op == OP_LOAD_H) fac[in_fac] <= in_value;
          if (accept && in_op == OP_START) begin
            r  <= '0;
            k  <= '0;
            st <= S_I_RD;
          end
        end
        S_I_RD: st <= S_I_MUL;
        S_I_MUL: begin
          colsum[k] <= (r == '0) ? 40'(w_s) : sat40(52'(colsum[k]) + 52'(w_s));
          st <= S_I_ACC;
        end
        S_I_ACC: begin
          msum <= msum_next;
          k    <= k + 1'b1;
          if (k_last && r_last) begin
            sweep_count <= '0;
            change_sum  <= ONE_Q16;
            st          <= S_CHK;
          end else begin
            if (k_last) r <= r + 1'b1;
            st <= S_I_RD;
          end
        end
        S_CHK: begin
          r <= '0;
          k <= '0;
          g <= '0;
          c <= '0;
          if (run_more) begin
            change_sum <= '0;
            st         <= S_R_RD;
          end else begin
            st <= S_EMIT;
          end
        end
        S_R_RD:  st <= S_R_DIV;
        S_R_DIV: st <= S_R_WAIT;
        S_R_WAIT: begin
          if (div_done) begin
            mu <= div_quo;
            st <= S_R_M1;
          end
        end
        S_R_M1: st <= S_R_M2;
        S_R_M2: begin
          mu2 <= sat32(52'(fl));
          st  <= S_R_M3;
        end
        S_R_M3: begin
          g  <= n1;
          st <= S_R_M4;
        end
        S_R_M4: begin
          c <= sat40(52'(c) + 52'(fl));
          r <= r + 1'b1;
          st <= r_last ? S_F_A : S_R_RD;
        end
        S_F_A: begin
          g  <= sat40(52'(g) - 52'(colsum[k]));
          a  <= sat32(52'(c) + $signed({28'd0, cfg.l2}));
          st <= S_F_M;
        end
        S_F_M: st <= S_F_N;
        S_F_N: begin
          num <= sat40(52'(n1) - $signed({28'd0, cfg.l1}));
          st  <= S_F_DIV;
        end
        S_F_DIV: st <= S_F_WAIT;
        S_F_WAIT: begin
          if (div_done) begin
            q  <= div_quo;
            st <= S_F_DEC;
          end
        end
        S_F_DEC: begin
          r <= '0;
          if (q[31]) begin
            change_sum <= ONE_Q16;
            qn         <= '0;
            st         <= S_U_RD;
          end else if (q != h) begin
            qn <= q;
            st <= S_C_WAIT;
          end else begin
            st <= S_F_END;
          end
        end
        S_C_WAIT: begin
          if (div_done) begin
            change_sum <= sat40(52'(change_sum) + 52'(div_quo));
            st         <= S_U_RD;
          end
        end
        S_U_RD: st <= S_U_M1;
        S_U_M1: st <= S_U_M2;
        S_U_M2: begin
          t  <= fl;
          st <= S_U_M3;
        end
        S_U_M3: begin
          r <= r + 1'b1;
          if (r_last) begin
            fac[k] <= qn;
            st     <= S_F_END;
          end else begin
            st <= S_U_RD;
          end
        end
        S_F_END: begin
          r <= '0;
          g <= '0;
          c <= '0;
          k <= k + 1'b1;
          if (k_last) begin
            sweep_count <= sweep_count + 1'b1;
            st          <= S_CHK;
          end else begin
            st <= S_R_RD;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            k <= k + 1'b1;
            if (k_last) st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign res_valid        = (st == S_EMIT);
  assign res.out_index    = k;
  assign res.factor_value = h;
  assign res.sweeps_used  = sweep_count;
  assign res.last         = k_last;

endmodule

// ===== hw/rtl/klcd_checker.sv =====
// Port-level checks of the solver top level, attached by bind.
// Depends on assert_macros.svh, klcd_pkg and kl_coordinate_descent_nmf.
`include "assert_macros.svh"

module klcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);
  import klcd_pkg::*;

  // a stalled result transaction holds its payload
  `KLCD_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // a start transaction makes the solver busy
  `KLCD_ASSERT(a_start_busy, clk, rst, s_tvalid && s_tready && s_tuser == OP_START |=> !s_tready, "input ready right after start")

  // no new input while a run still has results to hand out
  `KLCD_NEVER(a_run_blocks, clk, rst, m_tvalid && !m_tlast && s_tready, "input ready during result run")

  // the final result carries the highest factor index
  `KLCD_ASSERT(a_last_idx, clk, rst, m_tvalid && m_tlast |-> m_tdata[3:0] == 4'hF, "last result has wrong index")

endmodule

bind kl_coordinate_descent_nmf klcd_checker u_klcd_checker (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
